### rtl/core/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and constants for the escape-time pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package mbet_pkg;

  localparam int unsigned Scale      = 1536;
  localparam int unsigned MaxSteps   = 63;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned CntW       = 6;

  // real part: dc*Scale*3/320 = dc*72/5 ; imaginary: dr*Scale*9/4/200 = dr*432/25
  localparam int unsigned ReMul      = Scale * 3 / 64;     // 72
  localparam int unsigned ReDiv      = 5;
  localparam int unsigned ImMul      = Scale * 9 / 4 / 8;  // 432
  localparam int unsigned ImDiv      = 25;
  localparam int unsigned ReRecip    = 209716;   // ceil(2^20/5)
  localparam int unsigned ReShift    = 20;
  localparam int unsigned ImRecip    = 167773;   // ceil(2^22/25)
  localparam int unsigned ImShift    = 22;

  // square scaling: (s2 + Scale/2) / Scale = ((s2 + Scale/2) >> 9) / 3
  localparam int unsigned SqRound    = Scale / 2;
  localparam int unsigned SqShift    = 9;
  localparam int unsigned Div3Recip  = 2796203;  // ceil(2^23/3)
  localparam int unsigned Div3Shift  = 23;

  localparam logic [3:0] AddrCenterCol  = 4'h0;
  localparam logic [3:0] AddrCenterRow  = 4'h4;
  localparam logic [3:0] AddrEscLimit   = 4'h8;
  localparam logic [3:0] AddrMaxIter    = 4'hc;

  typedef struct packed {
    logic [CoordW-1:0] a;
    logic [CoordW-1:0] b;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CntW-1:0]   cnt;
    logic              hit;
  } pkt_t;

endpackage
`default_nettype wire

### rtl/core/mandelbrot_escape_time_sq_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_sq_table_core
// Escape-time count for one pixel, fully pipelined over 63 step units.
//
// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid/in_tready     pixel_col, pixel_row
// out_     out  out_tvalid/out_tready   count_left, escaped
// cfg_     in   APB psel/penable        four registers at 0x0..0xc
//
// The pipe is the setup stages and then 63 step units of three stages each
// (square, scale, test), which cover the largest 6-bit budget; one pixel enters
// per cycle while the pipe is not held.
// rst_n clears all valid bits and loads the register reset values.
// The whole pipe holds while the output stage is full and out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module mandelbrot_escape_time_sq_table_core import mbet_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,    // [9:0] pixel_col, [17:10] pixel_row
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [5:0] count_left, [6] escaped
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [9:0]  center_col_r;
  logic [7:0]  center_row_r;
  logic [15:0] escape_limit_r;
  logic [5:0]  max_iter_r;
  logic        en;
  logic        cfg_wr;

  logic [MaxSteps:0] vld;
  pkt_t              pkt [MaxSteps+1];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r   <= 10'd240;
      center_row_r   <= 8'd100;
      escape_limit_r <= 16'h1c00;
      max_iter_r     <= 6'd32;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        AddrCenterCol: center_col_r   <= cfg_pwdata[9:0];
        AddrCenterRow: center_row_r   <= cfg_pwdata[7:0];
        AddrEscLimit:  escape_limit_r <= cfg_pwdata[15:0];
        AddrMaxIter:   max_iter_r     <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      AddrCenterCol: cfg_prdata = {22'd0, center_col_r};
      AddrCenterRow: cfg_prdata = {24'd0, center_row_r};
      AddrEscLimit:  cfg_prdata = {16'd0, escape_limit_r};
      AddrMaxIter:   cfg_prdata = {26'd0, max_iter_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // advance everything unless the last stage holds an untaken transaction
  assign en        = !vld[MaxSteps] || out_tready;
  assign in_tready = en;

  mbet_setup u_setup (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .vld_i          (in_tvalid),
    .pixel_col      (in_tdata[9:0]),
    .pixel_row      (in_tdata[17:10]),
    .center_col     (center_col_r),
    .center_row     (center_row_r),
    .max_iterations (max_iter_r),
    .vld_o          (vld[0]),
    .pkt_o          (pkt[0])
  );

  for (genvar g = 0; g < MaxSteps; g++) begin : g_step
    mbet_iter u_iter (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .vld_i        (vld[g]),
      .pkt_i        (pkt[g]),
      .escape_limit (escape_limit_r),
      .vld_o        (vld[g+1]),
      .pkt_o        (pkt[g+1])
    );
  end

  assign out_tvalid = vld[MaxSteps];
  assign out_tdata  = {1'b0, pkt[MaxSteps].hit,
                       pkt[MaxSteps].hit ? pkt[MaxSteps].cnt : 6'd0};

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not track output stage");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[6]) |-> (out_tdata[5:0] == 6'd0))
    else $error("count nonzero on a point that never escaped");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6]) |-> (out_tdata[5:0] != 6'd0))
    else $error("escape reported with zero count");

endmodule
`default_nettype wire

### rtl/core/mbet_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_setup
// Two-stage mapping of pixel position to the fixed-point point c = a + i*b.
// ----------------------------------------------------------------------------
`default_nettype none
module mbet_setup import mbet_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        vld_i,
  input  wire logic [9:0]  pixel_col,
  input  wire logic [7:0]  pixel_row,
  input  wire logic [9:0]  center_col,
  input  wire logic [7:0]  center_row,
  input  wire logic [5:0]  max_iterations,
  output logic             vld_o,
  output pkt_t             pkt_o
);

  logic [10:0] dc_mag, dr_mag;
  logic        dc_neg, dr_neg;
  logic        v1_r;
  logic [16:0] re_n_r, re_n_nxt;
  logic [16:0] im_n_r, im_n_nxt;
  logic        re_neg_r, im_neg_r;
  logic [37:0] re_prod;
  logic [38:0] im_prod;
  logic [16:0] re_q, im_q;
  logic [CoordW-1:0] a_w, b_w;
  pkt_t        pkt_r;

  always_comb begin
    dc_neg   = (pixel_col < center_col);
    dr_neg   = (pixel_row < center_row);
    dc_mag   = dc_neg ? 11'(center_col - pixel_col) : 11'(pixel_col - center_col);
    dr_mag   = dr_neg ? 11'({2'b00, center_row} - {2'b00, pixel_row})
                      : 11'({2'b00, pixel_row} - {2'b00, center_row});
    re_n_nxt = 17'(dc_mag * 17'(ReMul));
    im_n_nxt = 17'(dr_mag * 17'(ImMul));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      v1_r  <= vld_i;
      vld_o <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_n_r   <= re_n_nxt;
      im_n_r   <= im_n_nxt;
      re_neg_r <= dc_neg;
      im_neg_r <= dr_neg;
      pkt_r    <= '{a: a_w, b: b_w, x: a_w, y: b_w, cnt: max_iterations, hit: 1'b0};
    end
  end

  // truncate toward zero: divide the magnitude, then restore the sign
  always_comb begin
    re_prod = 38'(re_n_r) * 38'(ReRecip);
    im_prod = 39'(im_n_r) * 39'(ImRecip);
    re_q    = re_prod[ReShift +: 17];
    im_q    = im_prod[ImShift +: 17];
    a_w     = (re_neg_r ? 16'(-re_q) : re_q[15:0]) & 16'hfffe;
    b_w     = (im_neg_r ? 16'(-im_q) : im_q[15:0]) & 16'hfffe;
  end

  assign pkt_o = pkt_r;

endmodule
`default_nettype wire

### rtl/core/mbet_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_iter
// One escape-time step in three stages: square, scale, test and update.
// ----------------------------------------------------------------------------
`default_nettype none
module mbet_iter import mbet_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        vld_i,
  input  pkt_t             pkt_i,
  input  wire logic [15:0] escape_limit,
  output logic             vld_o,
  output pkt_t             pkt_o
);

  logic              v1_r, v2_r;
  pkt_t              p1_r, p2_r, p3_r;
  logic [30:0]       sxx_r, syy_r, sxy_r;
  logic [15:0]       xx_r, yy_r, xy_r;
  logic [15:0]       sum_w;
  logic signed [15:0] sx, sy, sxy;
  logic signed [31:0] mxx, myy, mxy;
  logic [15:0]       qxx, qyy, qxy;
  logic [15:0]       zz;
  pkt_t              p3_nxt;

  function automatic logic [15:0] sq_scale(input logic [30:0] s2);
    logic [21:0] t;
    logic [44:0] m;
    begin
      t = 22'((32'(s2) + 32'(SqRound)) >> SqShift);
      m = 45'(t) * 45'(Div3Recip);
      sq_scale = m[Div3Shift +: 16] & 16'hfffe;
    end
  endfunction

  always_comb begin
    sum_w = pkt_i.x + pkt_i.y;
    sx    = signed'({pkt_i.x[15:1], 1'b0});
    sy    = signed'({pkt_i.y[15:1], 1'b0});
    sxy   = signed'({sum_w[15:1], 1'b0});
    mxx   = sx * sx;
    myy   = sy * sy;
    mxy   = sxy * sxy;
    qxx   = sq_scale(sxx_r);
    qyy   = sq_scale(syy_r);
    qxy   = sq_scale(sxy_r);
  end

  // test and update; a finished item passes through unchanged
  always_comb begin
    zz     = xx_r + yy_r;
    p3_nxt = p2_r;
    if (!p2_r.hit && p2_r.cnt != '0) begin
      if (zz > escape_limit) begin
        p3_nxt.hit = 1'b1;
      end else begin
        p3_nxt.y   = xy_r - zz + p2_r.b;
        p3_nxt.x   = p2_r.a + xx_r - yy_r;
        p3_nxt.cnt = p2_r.cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      v1_r  <= vld_i;
      v2_r  <= v1_r;
      vld_o <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= pkt_i;
      sxx_r <= mxx[30:0];
      syy_r <= myy[30:0];
      sxy_r <= mxy[30:0];
      p2_r  <= p1_r;
      xx_r  <= qxx;
      yy_r  <= qyy;
      xy_r  <= qxy;
      p3_r  <= p3_nxt;
    end
  end

  assign pkt_o = p3_r;

endmodule
`default_nettype wire
